// File: src/phc_pkg.sv
package phc_pkg;

  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_OUT_W     = 15;
  localparam int SAT_OUT_W     = 8;
  localparam int CLS_W         = 3;

  // hue sum t = hue/60 * diff, kept below 6*diff
  localparam int T_W   = 11;
  localparam int NUM_W = 17;

  localparam int DIV_STAGES = 5;

  localparam int HUE_Q_W   = 9 + HUE_FRAC_BITS;
  localparam int HUE_BPS   = (HUE_Q_W + DIV_STAGES - 1) / DIV_STAGES;
  localparam int HUE_QT    = HUE_BPS * DIV_STAGES;
  localparam int HUE_PAD   = HUE_QT - HUE_Q_W;
  localparam int HUE_DVD_W = HUE_QT + CH_W;

  localparam int SAT_Q_W   = 8;
  localparam int SAT_BPS   = (SAT_Q_W + DIV_STAGES - 1) / DIV_STAGES;
  localparam int SAT_QT    = SAT_BPS * DIV_STAGES;
  localparam int SAT_PAD   = SAT_QT - SAT_Q_W;
  localparam int SAT_DVD_W = SAT_QT + CH_W;

  localparam logic [CH_W-1:0] VALUE_FLOOR_RST = 8'd51;

  typedef enum logic [CLS_W-1:0] {
    CLS_NONE    = 3'd0,
    CLS_RED     = 3'd1,
    CLS_YELLOW  = 3'd2,
    CLS_GREEN   = 3'd3,
    CLS_BLUE    = 3'd4,
    CLS_MAGENTA = 3'd5
  } cls_t;

  typedef struct packed {
    logic [T_W-1:0]  t;
    logic [CH_W-1:0] diff;
    logic [CH_W-1:0] mx;
    logic            s_half;
    logic            s_45;
    logic            s_30;
    logic            s_35;
    logic            vflag;
  } front_t;

  typedef struct packed {
    logic [CH_W-1:0]   hue_rem;
    logic [HUE_QT-1:0] hue_dvd;
    logic [HUE_QT-1:0] hue_q;
    logic [CH_W-1:0]   diff;
    logic [CH_W-1:0]   sat_rem;
    logic [SAT_QT-1:0] sat_dvd;
    logic [SAT_QT-1:0] sat_q;
    logic [CH_W-1:0]   mx;
    logic              gray;
    cls_t              cls;
  } div_data_t;

endpackage

// File: src/phc_front.sv
module phc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        valid_i,
  input  logic [phc_pkg::PIX_W-1:0]   pixel_bgr,
  input  logic [phc_pkg::CH_W-1:0]    value_floor,
  output logic                        valid_o,
  output phc_pkg::front_t             data_o
);

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sec_t;

  logic [phc_pkg::CH_W-1:0] r, g, b, mx, mn;
  sec_t                     sec;
  logic signed [8:0]        delta;

  logic                     a_valid_r;
  logic [phc_pkg::CH_W-1:0] a_mx_r, a_diff_r;
  logic signed [8:0]        a_delta_r;
  sec_t                     a_sec_r;
  logic                     a_vflag_r;

  logic signed [11:0]       base, t_raw;
  logic [11:0]              six_diff;
  logic [12:0]              d13, m13;
  phc_pkg::front_t          b_nxt, b_r;
  logic                     b_valid_r;

  // stage a: max, min, sector
  always_comb begin
    b  = pixel_bgr[7:0];
    g  = pixel_bgr[15:8];
    r  = pixel_bgr[23:16];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (mx == r) begin
      sec   = SEC_RED;
      delta = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (mx == g) begin
      sec   = SEC_GREEN;
      delta = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sec   = SEC_BLUE;
      delta = $signed({1'b0, r}) - $signed({1'b0, g});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mx_r    <= mx;
      a_diff_r  <= mx - mn;
      a_delta_r <= delta;
      a_sec_r   <= sec;
      a_vflag_r <= (mx >= value_floor);
    end
  end

  // stage b: hue sum and saturation floors
  always_comb begin
    unique case (a_sec_r)
      SEC_RED:   base = 12'sd0;
      SEC_GREEN: base = $signed({4'b0, a_diff_r}) <<< 1;
      SEC_BLUE:  base = $signed({4'b0, a_diff_r}) <<< 2;
      default:   base = 12'sd0;
    endcase
    six_diff = 12'(a_diff_r) * 12'd6;
    t_raw    = base + 12'(a_delta_r);
    if (t_raw < 0) t_raw = t_raw + $signed(six_diff);
    d13 = 13'(a_diff_r);
    m13 = 13'(a_mx_r);
    b_nxt.t      = phc_pkg::T_W'(t_raw);
    b_nxt.diff   = a_diff_r;
    b_nxt.mx     = a_mx_r;
    b_nxt.s_half = (d13 * 13'd2) >= m13;
    b_nxt.s_45   = (d13 * 13'd20) >= (m13 * 13'd9);
    b_nxt.s_30   = (d13 * 13'd10) >= (m13 * 13'd3);
    b_nxt.s_35   = (d13 * 13'd20) >= (m13 * 13'd7);
    b_nxt.vflag  = a_vflag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r <= b_nxt;
    end
  end

  assign valid_o = b_valid_r;
  assign data_o  = b_r;

endmodule

// File: src/phc_classify.sv
module phc_classify (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                valid_i,
  input  phc_pkg::front_t     data_i,
  output logic                valid_o,
  output phc_pkg::div_data_t  data_o
);

  logic [phc_pkg::NUM_W-1:0]     num, dd;
  logic [phc_pkg::HUE_DVD_W-1:0] hue_dvd;
  logic [15:0]                   sat_prod;
  logic [phc_pkg::SAT_DVD_W-1:0] sat_dvd;
  logic                          w_red, w_yel, w_grn, w_blu, w_mag;
  phc_pkg::div_data_t            data_nxt, data_r;
  logic                          valid_r;

  always_comb begin
    num = phc_pkg::NUM_W'(data_i.t) * 17'd60;
    dd  = phc_pkg::NUM_W'(data_i.diff);
    w_red = (num <= dd * 17'd20) || (num >= dd * 17'd340);
    w_yel = (num >= dd * 17'd30)  && (num <= dd * 17'd55);
    w_grn = (num >= dd * 17'd100) && (num <= dd * 17'd175);
    w_blu = (num >= dd * 17'd185) && (num <= dd * 17'd245);
    w_mag = (num >= dd * 17'd295) && (num <= dd * 17'd335);

    hue_dvd  = phc_pkg::HUE_DVD_W'(num) << (phc_pkg::HUE_FRAC_BITS + phc_pkg::HUE_PAD);
    sat_prod = (16'(data_i.diff) << 8) - 16'(data_i.diff);
    sat_dvd  = phc_pkg::SAT_DVD_W'(sat_prod) << phc_pkg::SAT_PAD;

    data_nxt.hue_rem = hue_dvd[phc_pkg::HUE_DVD_W-1 -: phc_pkg::CH_W];
    data_nxt.hue_dvd = hue_dvd[phc_pkg::HUE_QT-1:0];
    data_nxt.hue_q   = '0;
    data_nxt.diff    = data_i.diff;
    data_nxt.sat_rem = sat_dvd[phc_pkg::SAT_DVD_W-1 -: phc_pkg::CH_W];
    data_nxt.sat_dvd = sat_dvd[phc_pkg::SAT_QT-1:0];
    data_nxt.sat_q   = '0;
    data_nxt.mx      = data_i.mx;
    data_nxt.gray    = (data_i.diff == '0);

    data_nxt.cls = phc_pkg::CLS_NONE;
    if (data_i.vflag) begin
      if (w_red && data_i.s_half) data_nxt.cls = phc_pkg::CLS_RED;
      else if (w_yel && data_i.s_45) data_nxt.cls = phc_pkg::CLS_YELLOW;
      else if (w_grn && data_i.s_30) data_nxt.cls = phc_pkg::CLS_GREEN;
      else if (w_blu && data_i.s_35) data_nxt.cls = phc_pkg::CLS_BLUE;
      else if (w_mag && data_i.s_30) data_nxt.cls = phc_pkg::CLS_MAGENTA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// File: src/phc_div_stage.sv
module phc_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                valid_i,
  input  phc_pkg::div_data_t  data_i,
  output logic                valid_o,
  output phc_pkg::div_data_t  data_o
);

  phc_pkg::div_data_t       data_nxt, data_r;
  logic [phc_pkg::CH_W:0]   trial;
  logic                     valid_r;

  // restoring division, a few quotient bits of hue and saturation per stage
  always_comb begin
    data_nxt = data_i;
    trial    = '0;
    for (int i = 0; i < phc_pkg::HUE_BPS; i++) begin
      trial = {data_nxt.hue_rem, data_nxt.hue_dvd[phc_pkg::HUE_QT-1]};
      data_nxt.hue_dvd = data_nxt.hue_dvd << 1;
      if (trial >= {1'b0, data_nxt.diff}) begin
        data_nxt.hue_rem = phc_pkg::CH_W'(trial - {1'b0, data_nxt.diff});
        data_nxt.hue_q   = {data_nxt.hue_q[phc_pkg::HUE_QT-2:0], 1'b1};
      end else begin
        data_nxt.hue_rem = trial[phc_pkg::CH_W-1:0];
        data_nxt.hue_q   = {data_nxt.hue_q[phc_pkg::HUE_QT-2:0], 1'b0};
      end
    end
    for (int j = 0; j < phc_pkg::SAT_BPS; j++) begin
      trial = {data_nxt.sat_rem, data_nxt.sat_dvd[phc_pkg::SAT_QT-1]};
      data_nxt.sat_dvd = data_nxt.sat_dvd << 1;
      if (trial >= {1'b0, data_nxt.mx}) begin
        data_nxt.sat_rem = phc_pkg::CH_W'(trial - {1'b0, data_nxt.mx});
        data_nxt.sat_q   = {data_nxt.sat_q[phc_pkg::SAT_QT-2:0], 1'b1};
      end else begin
        data_nxt.sat_rem = trial[phc_pkg::CH_W-1:0];
        data_nxt.sat_q   = {data_nxt.sat_q[phc_pkg::SAT_QT-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// File: src/pixel_hsv_color_classifier.sv
// pipeline: 8 register stages (3 front stages, 5 divider stages)
// throughput: one pixel per cycle; the whole pipeline holds while a result is stalled
// the five divider stages each resolve 3 hue and 2 saturation quotient bits
// reset: synchronous, active low; clears all stage valid bits, value_floor returns to 51
module pixel_hsv_color_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [phc_pkg::PIX_W-1:0]      in_pixel_bgr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [phc_pkg::HUE_OUT_W-1:0]  out_hue_deg64,
  output logic [phc_pkg::SAT_OUT_W-1:0]  out_saturation,
  output logic [phc_pkg::CH_W-1:0]       out_brightness,
  output logic [phc_pkg::CLS_W-1:0]      out_color_class,
  input  logic                           cfg_we,
  input  logic [phc_pkg::CH_W-1:0]       cfg_data
);

  logic [phc_pkg::CH_W-1:0]   value_floor_r;
  logic                       adv;
  logic                       front_valid;
  phc_pkg::front_t            front_data;
  logic                       stg_valid [phc_pkg::DIV_STAGES+1];
  phc_pkg::div_data_t         stg_data  [phc_pkg::DIV_STAGES+1];
  phc_pkg::div_data_t         last;
  logic [phc_pkg::HUE_QT-1:0] hue_sh;
  logic [phc_pkg::SAT_QT-1:0] sat_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_floor_r <= phc_pkg::VALUE_FLOOR_RST;
    end else if (cfg_we) begin
      value_floor_r <= cfg_data;
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  phc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .valid_i     (in_valid),
    .pixel_bgr   (in_pixel_bgr),
    .value_floor (value_floor_r),
    .valid_o     (front_valid),
    .data_o      (front_data)
  );

  phc_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (stg_valid[0]),
    .data_o  (stg_data[0])
  );

  for (genvar s = 0; s < phc_pkg::DIV_STAGES; s++) begin : g_div
    phc_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (stg_valid[s]),
      .data_i  (stg_data[s]),
      .valid_o (stg_valid[s+1]),
      .data_o  (stg_data[s+1])
    );
  end

  assign last   = stg_data[phc_pkg::DIV_STAGES];
  assign hue_sh = last.hue_q >> phc_pkg::HUE_PAD;
  assign sat_sh = last.sat_q >> phc_pkg::SAT_PAD;

  // gray pixels give zero hue and saturation
  assign out_valid       = stg_valid[phc_pkg::DIV_STAGES];
  assign out_hue_deg64   = last.gray ? '0 : phc_pkg::HUE_OUT_W'(hue_sh);
  assign out_saturation  = last.gray ? '0 : phc_pkg::SAT_OUT_W'(sat_sh);
  assign out_brightness  = last.mx;
  assign out_color_class = last.cls;

endmodule
